/* rtl/stm_pkg.sv */
// Shared sizes, request structs and address helper for the sparse-table
// range-minimum engine. No dependencies.

package stm_pkg;

  // Sizing of the engine
  localparam int MAX_ELEMENTS = 1024;
  localparam int TABLE_LEVELS = 11;
  localparam int DEPTH_BITS   = 8;

  // Fixed field widths at the ports
  localparam int POS_W   = 11;
  localparam int DEPTH_W = 8;
  localparam int KIND_W  = 2;

  // Derived internal widths
  localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
  localparam int IDX_W   = $clog2(MAX_ELEMENTS);
  localparam int LVL_W   = $clog2(TABLE_LEVELS);
  localparam int TAB_DEPTH = TABLE_LEVELS * MAX_ELEMENTS;
  localparam int TADDR_W = $clog2(TAB_DEPTH);
  localparam int WIDE_W  = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int CALC_W  = ((WIDE_W > TABLE_LEVELS) ? WIDE_W : TABLE_LEVELS) + 1;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BUILD  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd3;

  // Port bundle of the argmin table memory
  typedef struct packed {
    logic               we;
    logic [TADDR_W-1:0] waddr;
    logic [CNT_W-1:0]   wdata;
    logic [TADDR_W-1:0] raddr_a;
    logic [TADDR_W-1:0] raddr_b;
  } stm_tab_req_t;

  // Port bundle of the depth memory
  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [DEPTH_BITS-1:0] wdata;
    logic [IDX_W-1:0]      raddr_a;
    logic [IDX_W-1:0]      raddr_b;
  } stm_dep_req_t;

  // One result handed to the output register
  typedef struct packed {
    logic               valid;
    logic [POS_W-1:0]   pos;
    logic [DEPTH_W-1:0] depth;
    logic               err;
  } stm_res_t;

  // Flat table address: level-major, position-minor
  function automatic logic [TADDR_W-1:0] tab_addr(input logic [LVL_W-1:0] level,
                                                  input logic [IDX_W-1:0] idx);
    tab_addr = TADDR_W'(level) * TADDR_W'(MAX_ELEMENTS) + TADDR_W'(idx);
  endfunction

endpackage

/* rtl/sparse_table_range_min_top.sv */
// Top level of the sparse-table range-minimum engine: memories, sequencer
// and output register. Depends on stm_pkg, stm_ram and stm_seq.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------
//  request  | in_valid_i / in_ready_o    | kind_i, depth_value_i, left_pos_i,
//           |                            | right_pos_i
//  result   | out_valid_o / out_ready_i  | min_pos_o, min_depth_o, query_error_o
//
//  Clear and append are done in the idle state. A query walks range check, address,
//  table read, depth read and compare, shaped by the registered read data of the two
//  memories; a query with an error ends at the range check.
//  A build is accepted, writes level 0, then fills each higher level entry by
//  entry and starts each level with a table read; each entry waits on a table read
//  and a depth read.
//  Reset clears the count and the built flag; the memories are not cleared.
//  A result waiting in the output register does not stop new requests; only
//  the next result stalls until that register is free.

module sparse_table_range_min_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [stm_pkg::KIND_W-1:0]  kind_i,
  input  logic [stm_pkg::DEPTH_W-1:0] depth_value_i,
  input  logic [stm_pkg::POS_W-1:0]   left_pos_i,
  input  logic [stm_pkg::POS_W-1:0]   right_pos_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [stm_pkg::POS_W-1:0]   min_pos_o,
  output logic [stm_pkg::DEPTH_W-1:0] min_depth_o,
  output logic                        query_error_o
);

  stm_pkg::stm_tab_req_t            tab_req;
  stm_pkg::stm_dep_req_t            dep_req;
  stm_pkg::stm_res_t                res;
  logic [stm_pkg::CNT_W-1:0]        tab_rdata_a, tab_rdata_b;
  logic [stm_pkg::DEPTH_BITS-1:0]   dep_rdata_a, dep_rdata_b;
  logic                             slot_free;

  logic                             out_valid_q, out_valid_d;
  logic [stm_pkg::POS_W-1:0]        pos_q;
  logic [stm_pkg::DEPTH_W-1:0]      depth_q;
  logic                             err_q;

  // Argmin table, level-major
  stm_ram #(
    .WIDTH (stm_pkg::CNT_W),
    .DEPTH (stm_pkg::TAB_DEPTH)
  ) u_tab_ram (
    .clk_i     (clk_i),
    .we_i      (tab_req.we),
    .waddr_i   (tab_req.waddr),
    .wdata_i   (tab_req.wdata),
    .raddr_a_i (tab_req.raddr_a),
    .raddr_b_i (tab_req.raddr_b),
    .rdata_a_o (tab_rdata_a),
    .rdata_b_o (tab_rdata_b)
  );

  // Depth values by position
  stm_ram #(
    .WIDTH (stm_pkg::DEPTH_BITS),
    .DEPTH (stm_pkg::MAX_ELEMENTS)
  ) u_dep_ram (
    .clk_i     (clk_i),
    .we_i      (dep_req.we),
    .waddr_i   (dep_req.waddr),
    .wdata_i   (dep_req.wdata),
    .raddr_a_i (dep_req.raddr_a),
    .raddr_b_i (dep_req.raddr_b),
    .rdata_a_o (dep_rdata_a),
    .rdata_b_o (dep_rdata_b)
  );

  stm_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .depth_value_i (depth_value_i),
    .left_pos_i    (left_pos_i),
    .right_pos_i   (right_pos_i),
    .tab_req_o     (tab_req),
    .tab_rdata_a_i (tab_rdata_a),
    .tab_rdata_b_i (tab_rdata_b),
    .dep_req_o     (dep_req),
    .dep_rdata_a_i (dep_rdata_a),
    .dep_rdata_b_i (dep_rdata_b),
    .slot_free_i   (slot_free),
    .res_o         (res)
  );

  // Output register takes a new result when empty or being drained
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res.valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid) begin
      pos_q   <= res.pos;
      depth_q <= res.depth;
      err_q   <= res.err;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign min_pos_o     = pos_q;
  assign min_depth_o   = depth_q;
  assign query_error_o = err_q;

endmodule

/* rtl/stm_ram.sv */
// Generic single-write, dual-read synchronous RAM with registered read data.
// No dependencies.

module stm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_a_o,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Two read ports, registered read data
  always_ff @(posedge clk_i) begin
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

/* rtl/stm_seq.sv */
// Request sequencer: append/clear bookkeeping, table build walk and query
// walk over the shared read-compare path. Depends on stm_pkg.

module stm_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // request side
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [stm_pkg::KIND_W-1:0]   kind_i,
  input  logic [stm_pkg::DEPTH_W-1:0]  depth_value_i,
  input  logic [stm_pkg::POS_W-1:0]    left_pos_i,
  input  logic [stm_pkg::POS_W-1:0]    right_pos_i,
  // memories
  output stm_pkg::stm_tab_req_t        tab_req_o,
  input  logic [stm_pkg::CNT_W-1:0]    tab_rdata_a_i,
  input  logic [stm_pkg::CNT_W-1:0]    tab_rdata_b_i,
  output stm_pkg::stm_dep_req_t        dep_req_o,
  input  logic [stm_pkg::DEPTH_BITS-1:0] dep_rdata_a_i,
  input  logic [stm_pkg::DEPTH_BITS-1:0] dep_rdata_b_i,
  // result side
  input  logic                         slot_free_i,
  output stm_pkg::stm_res_t            res_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FILL0,
    S_LVL,
    S_QLEN,
    S_QADDR,
    S_TAB,
    S_DEP,
    S_EMIT
  } state_e;

  localparam int CW = stm_pkg::CALC_W;

  state_e                        state_q, state_d;
  logic [stm_pkg::CNT_W-1:0]     count_q, count_d;
  logic                          ready_q, ready_d;
  logic                          build_q, build_d;
  logic [stm_pkg::POS_W-1:0]     lo_q, lo_d;
  logic [stm_pkg::POS_W-1:0]     hi_q, hi_d;
  logic [stm_pkg::LVL_W-1:0]     k_q, k_d;
  logic [stm_pkg::LVL_W-1:0]     lvl_q, lvl_d;
  logic [stm_pkg::CNT_W-1:0]     idx_q, idx_d;
  logic [stm_pkg::CNT_W-1:0]     a_q, a_d;
  logic [stm_pkg::CNT_W-1:0]     b_q, b_d;
  logic [stm_pkg::POS_W-1:0]     rpos_q, rpos_d;
  logic [stm_pkg::DEPTH_W-1:0]   rdep_q, rdep_d;
  logic                          rerr_q, rerr_d;

  // Compare of the two candidates; ties go to the right one
  logic                          pick_a;
  logic [stm_pkg::CNT_W-1:0]     best_pos;
  logic [stm_pkg::DEPTH_BITS-1:0] best_dep;

  assign pick_a   = dep_rdata_a_i < dep_rdata_b_i;
  assign best_pos = pick_a ? a_q : b_q;
  assign best_dep = pick_a ? dep_rdata_a_i : dep_rdata_b_i;

  // Build walk helpers
  logic [CW-1:0] cnt_w, span_w, half_w, nxt_w, nlvl_w;
  logic [stm_pkg::LVL_W-1:0] prev_lvl, cur_lvl;

  assign cnt_w    = CW'(count_q);
  assign span_w   = CW'(1) << lvl_q;
  assign half_w   = span_w >> 1;
  assign nxt_w    = CW'(idx_q) + CW'(1);
  assign nlvl_w   = CW'(lvl_q) + CW'(1);
  assign cur_lvl  = lvl_q;
  assign prev_lvl = lvl_q - stm_pkg::LVL_W'(1);

  // Query length and span level
  logic [CW-1:0] len_w, kspan_w, bidx_w;
  logic          q_err;
  int            msb;

  assign len_w = CW'(hi_q) - CW'(lo_q) + CW'(1);
  assign q_err = !ready_q || (lo_q == '0) || (CW'(hi_q) > cnt_w);

  always_comb begin
    msb = 0;
    for (int b = 0; b < CW; b++) begin
      if (len_w[b]) msb = b;
    end
    if (msb > stm_pkg::TABLE_LEVELS - 1) msb = stm_pkg::TABLE_LEVELS - 1;
  end

  assign kspan_w = CW'(1) << k_q;
  assign bidx_w  = CW'(hi_q) - kspan_w;

  assign in_ready_o = (state_q == S_IDLE);

  // Next-state and memory request logic
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ready_d = ready_q;
    build_d = build_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    k_d     = k_q;
    lvl_d   = lvl_q;
    idx_d   = idx_q;
    a_d     = a_q;
    b_d     = b_q;
    rpos_d  = rpos_q;
    rdep_d  = rdep_q;
    rerr_d  = rerr_q;

    tab_req_o = '0;
    dep_req_o = '0;
    res_o     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (kind_i)
            stm_pkg::KIND_CLEAR: begin
              count_d = '0;
              ready_d = 1'b0;
            end
            stm_pkg::KIND_APPEND: begin
              if (CW'(count_q) < CW'(stm_pkg::MAX_ELEMENTS)) begin
                dep_req_o.we    = 1'b1;
                dep_req_o.waddr = count_q[stm_pkg::IDX_W-1:0];
                dep_req_o.wdata = stm_pkg::DEPTH_BITS'(depth_value_i);
                count_d         = count_q + stm_pkg::CNT_W'(1);
                ready_d         = 1'b0;
              end
            end
            stm_pkg::KIND_BUILD: begin
              build_d = 1'b1;
              idx_d   = '0;
              if (count_q == '0) begin
                ready_d = 1'b1;
              end else begin
                state_d = S_FILL0;
              end
            end
            stm_pkg::KIND_QUERY: begin
              build_d = 1'b0;
              if (left_pos_i > right_pos_i) begin
                lo_d = right_pos_i;
                hi_d = left_pos_i;
              end else begin
                lo_d = left_pos_i;
                hi_d = right_pos_i;
              end
              state_d = S_QLEN;
            end
            default: ;
          endcase
        end
      end

      // Level 0: every position is its own minimum
      S_FILL0: begin
        tab_req_o.we    = 1'b1;
        tab_req_o.waddr = stm_pkg::tab_addr('0, idx_q[stm_pkg::IDX_W-1:0]);
        tab_req_o.wdata = idx_q + stm_pkg::CNT_W'(1);
        idx_d           = idx_q + stm_pkg::CNT_W'(1);
        if (nxt_w == cnt_w) begin
          idx_d = '0;
          if ((stm_pkg::TABLE_LEVELS > 1) && (CW'(2) <= cnt_w)) begin
            lvl_d   = stm_pkg::LVL_W'(1);
            state_d = S_LVL;
          end else begin
            ready_d = 1'b1;
            state_d = S_IDLE;
          end
        end
      end

      // First reads of a level, in the cycle after the previous level's last write
      S_LVL: begin
        tab_req_o.raddr_a = stm_pkg::tab_addr(prev_lvl, idx_q[stm_pkg::IDX_W-1:0]);
        tab_req_o.raddr_b = stm_pkg::tab_addr(prev_lvl,
                              stm_pkg::IDX_W'(CW'(idx_q) + half_w));
        state_d = S_TAB;
      end

      // Range check and span level of a query
      S_QLEN: begin
        k_d = stm_pkg::LVL_W'(msb);
        if (q_err) begin
          if (slot_free_i) begin
            res_o.valid = 1'b1;
            res_o.err   = 1'b1;
            state_d     = S_IDLE;
          end else begin
            rpos_d  = '0;
            rdep_d  = '0;
            rerr_d  = 1'b1;
            state_d = S_EMIT;
          end
        end else begin
          state_d = S_QADDR;
        end
      end

      // Two overlapping spans of the query
      S_QADDR: begin
        tab_req_o.raddr_a = stm_pkg::tab_addr(k_q,
                              stm_pkg::IDX_W'(lo_q - stm_pkg::POS_W'(1)));
        tab_req_o.raddr_b = stm_pkg::tab_addr(k_q, bidx_w[stm_pkg::IDX_W-1:0]);
        state_d = S_TAB;
      end

      // Candidate positions back; fetch their depths
      S_TAB: begin
        a_d = tab_rdata_a_i;
        b_d = tab_rdata_b_i;
        dep_req_o.raddr_a = stm_pkg::IDX_W'(tab_rdata_a_i - stm_pkg::CNT_W'(1));
        dep_req_o.raddr_b = stm_pkg::IDX_W'(tab_rdata_b_i - stm_pkg::CNT_W'(1));
        state_d = S_DEP;
      end

      // Depths back; pick the minimum
      S_DEP: begin
        if (build_q) begin
          tab_req_o.we    = 1'b1;
          tab_req_o.waddr = stm_pkg::tab_addr(cur_lvl, idx_q[stm_pkg::IDX_W-1:0]);
          tab_req_o.wdata = best_pos;
          if (nxt_w + span_w <= cnt_w) begin
            // next entry of this level; reads hit the level below only
            idx_d = stm_pkg::CNT_W'(nxt_w);
            tab_req_o.raddr_a = stm_pkg::tab_addr(prev_lvl, stm_pkg::IDX_W'(nxt_w));
            tab_req_o.raddr_b = stm_pkg::tab_addr(prev_lvl,
                                  stm_pkg::IDX_W'(nxt_w + half_w));
            state_d = S_TAB;
          end else if ((nlvl_w < CW'(stm_pkg::TABLE_LEVELS)) &&
                       ((CW'(1) << nlvl_w) <= cnt_w)) begin
            lvl_d   = stm_pkg::LVL_W'(nlvl_w);
            idx_d   = '0;
            state_d = S_LVL;
          end else begin
            ready_d = 1'b1;
            state_d = S_IDLE;
          end
        end else if (slot_free_i) begin
          res_o.valid = 1'b1;
          res_o.pos   = stm_pkg::POS_W'(best_pos);
          res_o.depth = stm_pkg::DEPTH_W'(best_dep);
          res_o.err   = 1'b0;
          state_d     = S_IDLE;
        end else begin
          rpos_d  = stm_pkg::POS_W'(best_pos);
          rdep_d  = stm_pkg::DEPTH_W'(best_dep);
          rerr_d  = 1'b0;
          state_d = S_EMIT;
        end
      end

      // Held result waits for the output register
      S_EMIT: begin
        if (slot_free_i) begin
          res_o.valid = 1'b1;
          res_o.pos   = rpos_q;
          res_o.depth = rdep_q;
          res_o.err   = rerr_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      ready_q <= 1'b0;
      build_q <= 1'b0;
      lvl_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ready_q <= ready_d;
      build_q <= build_d;
      lvl_q   <= lvl_d;
      idx_q   <= idx_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    k_q    <= k_d;
    a_q    <= a_d;
    b_q    <= b_d;
    rpos_q <= rpos_d;
    rdep_q <= rdep_d;
    rerr_q <= rerr_d;
  end

endmodule
